// File: hw/rtl/acsc_pkg.sv
// Package for the adaptive chunk-size controller.
// Holds field widths, action and register codes, and the types shared by the modules.
// No dependencies.
package acsc_pkg;

  localparam int ACTION_W    = 2;
  localparam int NOW_W       = 64;
  localparam int CHUNK_OUT_W = 32;
  localparam int INTERVAL_W  = 32;
  localparam int BEAT_W      = 8;
  localparam int RATIO_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_POLL  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BEAT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HB_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CHUNK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_MODE      = 3'd4;

  localparam logic [INTERVAL_W-1:0] RST_HB_INTERVAL  = 32'd100000;
  localparam logic [BEAT_W-1:0]     RST_WINDOW_SIZE  = 8'd8;
  localparam logic [RATIO_W-1:0]    RST_TARGET_RATIO = 8'd2;
  localparam logic                  RST_ACC_MODE     = 1'b0;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_BEAT  = 2'd1,
    OP_START = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [NOW_W-1:0] now;
  } q_item_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] hb_interval;
    logic [BEAT_W-1:0]     window_size;
    logic [RATIO_W-1:0]    target_ratio;
    logic                  acc_mode;
    logic                  chunk_load;
    logic [CFG_DATA_W-1:0] chunk_value;
  } cfg_t;

endpackage

// File: hw/rtl/acsc_if.sv
// Channel interfaces of the adaptive chunk-size controller.
// One interface for input items and one for result items; uses acsc_pkg.
interface acsc_in_if import acsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [NOW_W-1:0]    now;

  modport source(output valid, action, now, input ready);
  modport sink(input valid, action, now, output ready);
endinterface

interface acsc_out_if import acsc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   heartbeat_due;
  logic [CHUNK_OUT_W-1:0] chunk_size;
  logic                   window_done;

  modport source(output valid, heartbeat_due, chunk_size, window_done, input ready);
  modport sink(input valid, heartbeat_due, chunk_size, window_done, output ready);
endinterface

// File: hw/rtl/acsc_front.sv
// Front end of the adaptive chunk-size controller.
// Accepts input transactions, decodes the action and queues them in a two-entry queue.
// Uses acsc_pkg and acsc_in_if.
module acsc_front import acsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  acsc_in_if.sink    in_ch,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  q_item_t    entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  op_t        op_dec;

  always_comb begin
    unique case (in_ch.action)
      ACT_POLL:  op_dec = OP_POLL;
      ACT_BEAT:  op_dec = OP_BEAT;
      ACT_START: op_dec = OP_START;
      default:   op_dec = OP_NOP;
    endcase
  end

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= '{op: op_dec, now: in_ch.now};
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/acsc_back.sv
// Back end of the adaptive chunk-size controller.
// Executes queued items, holds the task and window state, and runs the serial
// multiply and restoring divide of the chunk update. Uses acsc_pkg and acsc_out_if.
module acsc_back import acsc_pkg::*; #(
  parameter int CHUNK_BITS = 32,
  parameter int POLL_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  acsc_out_if.source out_ch
);

  localparam int PW    = POLL_BITS + CHUNK_BITS;
  localparam int CNT_W = $clog2(PW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WRITE
  } state_t;

  state_t                state_r;
  logic [NOW_W-1:0]      start_time_r;
  logic [POLL_BITS-1:0]  task_cnt_r;
  logic [POLL_BITS-1:0]  win_cnt_r;
  logic [BEAT_W-1:0]     beat_cnt_r;
  logic [CHUNK_BITS-1:0] chunk_r;
  logic [POLL_BITS-1:0]  mplier_r;
  logic [PW-1:0]         prod_r;
  logic [RATIO_W-1:0]    rem_r;
  logic [CNT_W-1:0]      step_r;
  logic                  out_valid_r;
  logic                  due_r;
  logic                  done_r;
  logic [CHUNK_BITS-1:0] chunk_out_r;

  logic                  out_free;
  logic                  issue;
  logic                  out_load;
  logic [NOW_W:0]        elapsed;
  logic                  due;
  logic [POLL_BITS-1:0]  folded;
  logic [BEAT_W-1:0]     beat_inc;
  logic                  closes;
  logic [POLL_BITS-1:0]  restart_val;
  logic [RATIO_W-1:0]    divisor;
  logic [RATIO_W:0]      rem_shift;
  logic                  rem_ge;
  logic [CHUNK_BITS-1:0] quot_sat;
  logic [CHUNK_BITS-1:0] new_chunk;
  logic [NOW_W-1:0]      load_ext;
  logic [CHUNK_BITS-1:0] load_val;
  logic [NOW_W-1:0]      chunk_ext;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign issue       = (state_r == S_IDLE) && q_valid && out_free;
  assign q_pop       = issue;
  assign out_load    = (issue && !((q_item.op == OP_BEAT) && closes)) ||
                       ((state_r == S_WRITE) && out_free);

  assign elapsed     = {1'b0, q_item.now} - {1'b0, start_time_r};
  assign due         = !elapsed[NOW_W] &&
                       (elapsed[NOW_W-1:0] >= {{(NOW_W-INTERVAL_W){1'b0}}, cfg.hb_interval});

  assign folded      = cfg.acc_mode ? ((task_cnt_r > win_cnt_r) ? task_cnt_r : win_cnt_r)
                                    : ((task_cnt_r < win_cnt_r) ? task_cnt_r : win_cnt_r);
  assign beat_inc    = beat_cnt_r + BEAT_W'(1);
  assign closes      = (beat_inc >= cfg.window_size);
  assign restart_val = cfg.acc_mode ? '0 : '1;

  assign divisor     = (cfg.target_ratio == '0) ? RATIO_W'(1) : cfg.target_ratio;
  assign rem_shift   = {rem_r, prod_r[PW-1]};
  assign rem_ge      = (rem_shift >= {1'b0, divisor});

  assign quot_sat    = (|prod_r[PW-1:CHUNK_BITS]) ? '1 : prod_r[CHUNK_BITS-1:0];
  assign new_chunk   = (quot_sat == '0) ? CHUNK_BITS'(1) : quot_sat;

  assign load_ext    = NOW_W'(cfg.chunk_value);
  assign load_val    = (load_ext[CHUNK_BITS-1:0] == '0) ? CHUNK_BITS'(1)
                                                        : load_ext[CHUNK_BITS-1:0];

  assign chunk_ext            = NOW_W'(chunk_out_r);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.heartbeat_due = due_r;
  assign out_ch.window_done   = done_r;
  assign out_ch.chunk_size    = chunk_ext[CHUNK_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_time_r <= '0;
      task_cnt_r   <= '0;
      win_cnt_r    <= '1;
      beat_cnt_r   <= '0;
      chunk_r      <= CHUNK_BITS'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (issue) begin
            unique case (q_item.op)
              OP_POLL: begin
                if (task_cnt_r != '1) begin
                  task_cnt_r <= task_cnt_r + POLL_BITS'(1);
                end
                due_r       <= due;
                done_r      <= 1'b0;
                chunk_out_r <= chunk_r;
              end
              OP_BEAT: begin
                if (closes) begin
                  beat_cnt_r <= '0;
                  mplier_r   <= folded;
                  prod_r     <= '0;
                  step_r     <= '0;
                  state_r    <= S_MUL;
                end else begin
                  win_cnt_r   <= folded;
                  beat_cnt_r  <= beat_inc;
                  due_r       <= 1'b0;
                  done_r      <= 1'b0;
                  chunk_out_r <= chunk_r;
                end
              end
              OP_START: begin
                task_cnt_r   <= '0;
                start_time_r <= q_item.now;
                due_r        <= 1'b0;
                done_r       <= 1'b0;
                chunk_out_r  <= chunk_r;
              end
              OP_NOP: begin
                due_r       <= 1'b0;
                done_r      <= 1'b0;
                chunk_out_r <= chunk_r;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_r   <= {prod_r[PW-2:0], 1'b0} +
                      (mplier_r[POLL_BITS-1] ? {{POLL_BITS{1'b0}}, chunk_r} : '0);
          mplier_r <= {mplier_r[POLL_BITS-2:0], 1'b0};
          if (step_r == CNT_W'(POLL_BITS - 1)) begin
            step_r  <= '0;
            rem_r   <= '0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r + CNT_W'(1);
          end
        end
        S_DIV: begin
          rem_r  <= rem_ge ? RATIO_W'(rem_shift - {1'b0, divisor}) : rem_shift[RATIO_W-1:0];
          prod_r <= {prod_r[PW-2:0], rem_ge};
          if (step_r == CNT_W'(PW - 1)) begin
            state_r <= S_WRITE;
          end else begin
            step_r <= step_r + CNT_W'(1);
          end
        end
        S_WRITE: begin
          if (out_free) begin
            win_cnt_r   <= restart_val;
            due_r       <= 1'b0;
            done_r      <= 1'b1;
            chunk_out_r <= new_chunk;
            state_r     <= S_IDLE;
          end
        end
      endcase
      if (cfg.chunk_load) begin
        chunk_r <= load_val;
      end else if ((state_r == S_WRITE) && out_free) begin
        chunk_r <= new_chunk;
      end
    end
  end

endmodule

// File: hw/rtl/adaptive_chunk_size_controller.sv
// Adaptive chunk-size controller: poll timer and window-based chunk-size control.
// Polls, task starts and heartbeats that do not close a window give their result
// through the queue entry and the output register, one item per cycle while out_ch
// is not stalled; a window-closing heartbeat first runs the serial multiply and
// divide and holds off new items. Reset is synchronous; there is no clearing pass.
module adaptive_chunk_size_controller import acsc_pkg::*; #(
  parameter int CHUNK_BITS = 32,
  parameter int POLL_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  acsc_in_if.sink               in_ch,
  acsc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [INTERVAL_W-1:0] hb_interval_r;
  logic [BEAT_W-1:0]     window_size_r;
  logic [RATIO_W-1:0]    target_ratio_r;
  logic                  acc_mode_r;
  cfg_t                  cfg;
  logic                  q_valid;
  q_item_t               q_item;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_interval_r  <= RST_HB_INTERVAL;
      window_size_r  <= RST_WINDOW_SIZE;
      target_ratio_r <= RST_TARGET_RATIO;
      acc_mode_r     <= RST_ACC_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HB_INTERVAL:  hb_interval_r  <= cfg_wdata[INTERVAL_W-1:0];
        REG_WINDOW_SIZE:  window_size_r  <= cfg_wdata[BEAT_W-1:0];
        REG_TARGET_RATIO: target_ratio_r <= cfg_wdata[RATIO_W-1:0];
        REG_ACC_MODE:     acc_mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.hb_interval  = hb_interval_r;
  assign cfg.window_size  = window_size_r;
  assign cfg.target_ratio = target_ratio_r;
  assign cfg.acc_mode     = acc_mode_r;
  assign cfg.chunk_load   = rst_n && cfg_we && (cfg_index == REG_INITIAL_CHUNK);
  assign cfg.chunk_value  = cfg_wdata;

  acsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  acsc_back #(
    .CHUNK_BITS (CHUNK_BITS),
    .POLL_BITS  (POLL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/acsc_checker.sv
// Port-level checker for the adaptive chunk-size controller.
// Watches the result channel over time; bound to the top level below.
module acsc_checker import acsc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_heartbeat_due,
  input logic [CHUNK_OUT_W-1:0] out_chunk_size,
  input logic                   out_window_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chunk_size) &&
      $stable(out_heartbeat_due) && $stable(out_window_done))
    else $error("result changed while stalled");

  a_due_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_heartbeat_due && out_window_done))
    else $error("poll and window close flagged in one result");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_done |-> out_chunk_size != '0)
    else $error("recomputed chunk size is zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind adaptive_chunk_size_controller acsc_checker u_acsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_heartbeat_due (out_ch.heartbeat_due),
  .out_chunk_size    (out_ch.chunk_size),
  .out_window_done   (out_ch.window_done)
);
